@@ design/des_pkg.sv @@
// des_pkg: shared types, standard tables and bit permutation functions
// for the des block cipher pipeline
// no dependencies
package des_pkg;

  // one pipeline slot: control, feistel halves and key schedule halves
  typedef struct packed {
    logic        valid;
    logic        decrypt;
    logic [31:0] l;
    logic [31:0] r;
    logic [55:0] cd;
  } stage_t;

  localparam int unsigned ROUNDS = 16;

  // opcode values
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [6:0] TAB_IP [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

  localparam logic [6:0] TAB_FP [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

  localparam logic [5:0] TAB_E [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

  localparam logic [5:0] TAB_P [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

  localparam logic [6:0] TAB_PC1 [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

  localparam logic [5:0] TAB_PC2 [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
    6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
    6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
    6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
    6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

  // left shifts per round when encrypting
  localparam logic [1:0] ROT_ENC [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1};

  // right shifts per round when decrypting (round keys in reverse order)
  localparam logic [1:0] ROT_DEC [16] = '{
    2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1};

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  // table entries count bits from 1 at the msb
  function automatic logic [63:0] perm_ip(logic [63:0] src);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) res[63-i] = src[64 - int'(TAB_IP[i])];
    return res;
  endfunction

  function automatic logic [63:0] perm_fp(logic [63:0] src);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) res[63-i] = src[64 - int'(TAB_FP[i])];
    return res;
  endfunction

  function automatic logic [55:0] perm_pc1(logic [63:0] src);
    logic [55:0] res;
    for (int i = 0; i < 56; i++) res[55-i] = src[64 - int'(TAB_PC1[i])];
    return res;
  endfunction

  function automatic logic [47:0] perm_pc2(logic [55:0] src);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) res[47-i] = src[56 - int'(TAB_PC2[i])];
    return res;
  endfunction

  function automatic logic [47:0] expand_e(logic [31:0] src);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) res[47-i] = src[32 - int'(TAB_E[i])];
    return res;
  endfunction

  function automatic logic [31:0] perm_p(logic [31:0] src);
    logic [31:0] res;
    for (int i = 0; i < 32; i++) res[31-i] = src[32 - int'(TAB_P[i])];
    return res;
  endfunction

  // eight s-box lookups, outer bits select the row
  function automatic logic [31:0] sbox_layer(logic [47:0] x);
    logic [31:0] res;
    logic [5:0]  six;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      res[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
    end
    return res;
  endfunction

  function automatic logic [27:0] rotl28(logic [27:0] v, logic [1:0] k);
    case (k)
      2'd1:    return {v[26:0], v[27]};
      2'd2:    return {v[25:0], v[27:26]};
      default: return v;
    endcase
  endfunction

  function automatic logic [27:0] rotr28(logic [27:0] v, logic [1:0] k);
    case (k)
      2'd1:    return {v[0], v[27:1]};
      2'd2:    return {v[1:0], v[27:2]};
      default: return v;
    endcase
  endfunction

endpackage

@@ design/des_round_cell.sv @@
// des_round_cell: one registered feistel round with its key schedule step
// depends on des_pkg (stage_t, tables, permutation functions)
module des_round_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic [3:0]      round_idx,
  input  des_pkg::stage_t cell_in,
  output des_pkg::stage_t cell_out
);

  logic [27:0] c_rot;
  logic [27:0] d_rot;
  logic [47:0] subkey;
  logic [31:0] f_out;

  always_comb begin
    if (cell_in.decrypt == des_pkg::OP_DECRYPT) begin
      c_rot = des_pkg::rotr28(cell_in.cd[55:28], des_pkg::ROT_DEC[round_idx]);
      d_rot = des_pkg::rotr28(cell_in.cd[27:0], des_pkg::ROT_DEC[round_idx]);
    end else begin
      c_rot = des_pkg::rotl28(cell_in.cd[55:28], des_pkg::ROT_ENC[round_idx]);
      d_rot = des_pkg::rotl28(cell_in.cd[27:0], des_pkg::ROT_ENC[round_idx]);
    end
    subkey = des_pkg::perm_pc2({c_rot, d_rot});
    f_out  = des_pkg::perm_p(des_pkg::sbox_layer(des_pkg::expand_e(cell_in.r) ^ subkey));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= cell_in.valid;
    end
    cell_out.decrypt <= cell_in.decrypt;
    cell_out.l       <= cell_in.r;
    cell_out.r       <= cell_in.l ^ f_out;
    cell_out.cd      <= {c_rot, d_rot};
  end

endmodule

@@ design/des_block_cipher.sv @@
// des_block_cipher: pipelined des ecb engine, sixteen round cells in a row
// depends on des_pkg and des_round_cell
//
//   channel   signals                              direction  notes
//   request   start, busy, opcode, data_block      in         taken when start && !busy
//   result    done, out_block                      out        one-cycle strobe, no backpressure
//   key       key_valid, key_ready, key_data       in         64-bit key incl. parity
//
// one request per cycle, every cycle; busy is always low
// from accept to done a request passes the entry register, 16 round cells and the output register
// each round cell carries its own rotated key halves, so the key schedule rides with the data
// synchronous reset clears the key to 0 and all slot valid bits; no clearing pass
// write the key only while the pipeline is empty
// the result cannot be stalled: done is high for exactly one cycle per request
module des_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [63:0] data_block,
  output logic        done,
  output logic [63:0] out_block,
  input  logic        key_valid,
  output logic        key_ready,
  input  logic [63:0] key_data
);

  // key register, reset value 0
  logic [63:0] cipher_key;

  // stage 0 is the entry register, stage k+1 is the output of round cell k
  des_pkg::stage_t stg [des_pkg::ROUNDS+1];

  logic [63:0] ip_block;
  logic        accept;

  // pipeline never stalls, key register always writable
  assign busy      = 1'b0;
  assign key_ready = 1'b1;
  assign accept    = start && !busy;
  assign ip_block  = des_pkg::perm_ip(data_block);

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= 64'd0;
    end else if (key_valid && key_ready) begin
      cipher_key <= key_data;
    end
  end

  // entry register: initial permutation and pc-1 of the key
  always_ff @(posedge clk) begin
    if (rst) begin
      stg[0].valid <= 1'b0;
    end else begin
      stg[0].valid <= accept;
    end
    stg[0].decrypt <= opcode;
    stg[0].l       <= ip_block[63:32];
    stg[0].r       <= ip_block[31:0];
    stg[0].cd      <= des_pkg::perm_pc1(cipher_key);
  end

  // row of round cells
  for (genvar k = 0; k < des_pkg::ROUNDS; k++) begin : g_round
    des_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .round_idx (4'(k)),
      .cell_in   (stg[k]),
      .cell_out  (stg[k+1])
    );
  end

  // output register: final swap and final permutation
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stg[des_pkg::ROUNDS].valid;
    end
    out_block <= des_pkg::perm_fp({stg[des_pkg::ROUNDS].r, stg[des_pkg::ROUNDS].l});
  end

  // an accepted request occupies the entry slot on the next cycle
  a_entry_fill: assert property (@(posedge clk) disable iff (rst)
    accept |=> stg[0].valid)
    else $error("accepted request did not enter the pipeline");

  // every strobe comes from a request in the last round cell
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(stg[des_pkg::ROUNDS].valid))
    else $error("done without a request leaving the last round");

  // a request advances one cell per cycle, checked here from the entry slot to the first round cell
  a_advance: assert property (@(posedge clk) disable iff (rst)
    stg[0].valid |=> stg[1].valid)
    else $error("request lost between entry and first round");

  // no strobe right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("done raised right after reset");

endmodule
